### src/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property that must also hold during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/dmbf_pkg.sv
//------------------------------------------------------------------------------
// dmbf_pkg
// types and constants of the display mode best fit selector
//------------------------------------------------------------------------------
`default_nettype none

package dmbf_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_TARGET_WIDTH  = 1'b0;
    localparam logic REG_TARGET_HEIGHT = 1'b1;
    localparam logic [15:0] TARGET_WIDTH_RST  = 16'd640;
    localparam logic [15:0] TARGET_HEIGHT_RST = 16'd480;

    // qualification codes
    localparam logic [15:0] ATTR_SUPPORTED = 16'h0001;
    localparam logic [15:0] ATTR_COLOUR    = 16'h0008;
    localparam logic [15:0] ATTR_GRAPHICS  = 16'h0010;
    localparam logic [15:0] ATTR_LINEAR    = 16'h0080;
    localparam logic [15:0] ATTR_REQUIRED  =
        ATTR_SUPPORTED | ATTR_COLOUR | ATTR_GRAPHICS | ATTR_LINEAR;
    localparam logic [7:0]  MODEL_PACKED   = 8'd4;
    localparam logic [7:0]  MODEL_DIRECT   = 8'd6;
    localparam logic [7:0]  DEPTH_LOW      = 8'd16;
    localparam logic [7:0]  DEPTH_HIGH     = 8'd32;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        is_terminator;
        logic        info_ok;
        logic [15:0] mode_number;
        logic [15:0] attributes;
        logic [7:0]  memory_model;
        logic [7:0]  pixel_depth;
        logic [15:0] mode_width;
        logic [15:0] mode_height;
    } t_mode_in;

    typedef struct packed {
        logic        found;
        logic [15:0] chosen_mode;
        logic [15:0] chosen_width;
        logic [15:0] chosen_height;
        logic [7:0]  chosen_depth;
        logic [7:0]  chosen_model;
    } t_result;

    // classified descriptor
    typedef struct packed {
        logic        is_term;
        logic        exact;
        logic        fits;
        logic [15:0] mode;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth;
        logic [7:0]  model;
    } t_cls;

endpackage

`default_nettype wire

### src/dmbf_front.sv
//------------------------------------------------------------------------------
// dmbf_front
// target registers and descriptor classification
//------------------------------------------------------------------------------
`default_nettype none

module dmbf_front
    import dmbf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    input  wire logic                  i_push,
    input  wire t_mode_in              i_item,
    input  wire logic                  i_queue_full,
    output logic                       o_push,
    output t_cls                       o_cls
);

    logic [15:0] r_target_w, n_target_w;
    logic [15:0] r_target_h, n_target_h;
    logic        wr_en;
    logic        qualify;

    assign wr_en = psel && penable && pwrite;

    always_comb begin
        n_target_w = r_target_w;
        n_target_h = r_target_h;
        if (wr_en) begin
            case (paddr[2])
                REG_TARGET_WIDTH:  n_target_w = pwdata[15:0];
                REG_TARGET_HEIGHT: n_target_h = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_w <= TARGET_WIDTH_RST;
            r_target_h <= TARGET_HEIGHT_RST;
        end else begin
            r_target_w <= n_target_w;
            r_target_h <= n_target_h;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TARGET_WIDTH:  prdata = {{(CFG_DATA_W-16){1'b0}}, r_target_w};
            REG_TARGET_HEIGHT: prdata = {{(CFG_DATA_W-16){1'b0}}, r_target_h};
            default:           prdata = '0;
        endcase
    end

    // failed fetches never qualify
    assign qualify = i_item.info_ok
        && ((i_item.attributes & ATTR_REQUIRED) == ATTR_REQUIRED)
        && (i_item.memory_model == MODEL_PACKED || i_item.memory_model == MODEL_DIRECT)
        && (i_item.pixel_depth == DEPTH_LOW || i_item.pixel_depth == DEPTH_HIGH);

    always_comb begin
        o_cls.is_term = i_item.is_terminator;
        o_cls.exact   = !i_item.is_terminator && qualify
            && i_item.mode_width == r_target_w && i_item.mode_height == r_target_h
            && i_item.pixel_depth == DEPTH_HIGH;
        o_cls.fits    = !i_item.is_terminator && qualify
            && i_item.mode_width <= r_target_w && i_item.mode_height <= r_target_h;
        o_cls.mode    = i_item.mode_number;
        o_cls.width   = i_item.mode_width;
        o_cls.height  = i_item.mode_height;
        o_cls.depth   = i_item.pixel_depth;
        o_cls.model   = i_item.memory_model;
    end

    assign o_push = i_push && !i_queue_full;

endmodule

`default_nettype wire

### src/dmbf_queue.sv
//------------------------------------------------------------------------------
// dmbf_queue
// short register queue of classified descriptors
//------------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmbf_queue
    import dmbf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_data,
    output logic      o_full,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_cls      o_data
);

    t_cls                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk,
        !i_rst_n || r_count <= QUEUE_CNT_W'(QUEUE_DEPTH),
        "queue count beyond depth")
    `ASSERT_CLKD(a_count_grow, i_clk, i_rst_n,
        do_push && !do_pop |=> r_count == $past(r_count) + 1'b1,
        "queue count did not grow on push")

endmodule

`default_nettype wire

### src/dmbf_back.sv
//------------------------------------------------------------------------------
// dmbf_back
// best fit tracking and result register
//------------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dmbf_back
    import dmbf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_cls i_cls,
    output logic      o_take,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_result   o_result
);

    logic    r_locked, n_locked;
    t_result r_best, n_best;
    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;
    logic    out_ready;
    t_result cand;

    assign out_ready = !r_out_valid || i_pop;
    // a terminator waits for room in the result register
    assign o_take    = i_valid && (!i_cls.is_term || out_ready);

    assign cand.found         = 1'b1;
    assign cand.chosen_mode   = i_cls.mode;
    assign cand.chosen_width  = i_cls.width;
    assign cand.chosen_height = i_cls.height;
    assign cand.chosen_depth  = i_cls.depth;
    assign cand.chosen_model  = i_cls.model;

    always_comb begin
        n_locked    = r_locked;
        n_best      = r_best;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        if (o_take) begin
            if (i_cls.is_term) begin
                n_out_valid = 1'b1;
                n_out       = r_best;
                n_locked    = 1'b0;
                n_best      = '0;
            end else if (!r_locked) begin
                if (i_cls.exact) begin
                    n_best   = cand;
                    n_locked = 1'b1;
                end else if (i_cls.fits && i_cls.width >= r_best.chosen_width
                             && i_cls.height >= r_best.chosen_height) begin
                    n_best = cand;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked    <= 1'b0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_locked    <= n_locked;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    `ASSERT_CLKD(a_lock_implies_found, i_clk, i_rst_n, r_locked |-> r_best.found,
        "exact lock without a chosen mode")
    `ASSERT_CLKD(a_term_clears, i_clk, i_rst_n,
        o_take && i_cls.is_term |=> !r_locked && !r_best.found,
        "terminator did not clear the best fit")

endmodule

`default_nettype wire

### src/display_mode_best_fit_select.sv
//------------------------------------------------------------------------------
// display_mode_best_fit_select
// picks the best display mode for a target resolution from a descriptor list
//------------------------------------------------------------------------------
// usage:
//   descriptors enter on the push/full channel, one beat each; the list ends
//   with a terminator beat. target width and height are set over the apb port
//   (byte address 0 and 4) while the block is idle; pready is always high.
//   each terminator yields one result beat on the empty/pop channel holding
//   the chosen mode, or found = 0 and zeros when nothing qualified.
//   a terminator passes through the classification queue; the back end then
//   loads the result register from it when that register is free.
//   throughput: one descriptor per cycle while full is low; the best fit
//   compare in the back end is combinational.
//   a stalled result holds in the result register; descriptors keep flowing
//   until the next terminator reaches the back end, then the two-entry queue
//   fills and full rises.
//   synchronous reset restores the targets to 640 x 480 and clears the
//   running best fit, the queue and the pending result.
//------------------------------------------------------------------------------
`default_nettype none

module display_mode_best_fit_select
    import dmbf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    // descriptor channel
    input  wire logic                  push,
    output logic                       full,
    input  wire t_mode_in              i_item,
    // result channel
    output logic                       empty,
    input  wire logic                  pop,
    output t_result                    o_result
);

    logic q_push;
    t_cls q_in;
    logic q_empty;
    t_cls q_out;
    logic q_pop;

    assign pready = 1'b1;

    // front: targets and classification of each beat
    dmbf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .i_push       (push),
        .i_item       (i_item),
        .i_queue_full (full),
        .o_push       (q_push),
        .o_cls        (q_in)
    );

    // decoupling queue so either side may stall alone
    dmbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    // back: running best fit and result register
    dmbf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_cls    (q_out),
        .o_take   (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
